// File: rtl/mbp_pkg.sv
// ----------------------------------------------------------------------------
// mbp_pkg
// Shared types and constants for the row-to-page bitmap transposer.
// ----------------------------------------------------------------------------
package mbp_pkg;

    localparam int PANEL_WIDTH  = 128;
    localparam int PANEL_HEIGHT = 64;
    localparam int ROW_BYTES    = PANEL_WIDTH / 8;
    localparam int COL_AW       = $clog2(ROW_BYTES);
    localparam int PAGE_ROWS    = 8;
    localparam int WORD_W       = PAGE_ROWS * 8;

    localparam logic [5:0] PAGE_MASK = 6'h38;
    localparam logic [2:0] LAST_SUB  = 3'd7;

    typedef enum logic [1:0] {
        REG_FIRST_COLUMN = 2'd0,
        REG_LAST_COLUMN  = 2'd1,
        REG_FIRST_ROW    = 2'd2,
        REG_LAST_ROW     = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [7:0] src_byte;
        logic [5:0] row_index;
        logic [3:0] byte_column;
    } in_item_t;

    typedef struct packed {
        logic [7:0] page_byte;
        logic [2:0] page_number;
        logic [6:0] pixel_column;
        logic       run_last;
    } out_item_t;

    typedef struct packed {
        logic [6:0] first_column;
        logic [6:0] last_column;
        logic [5:0] first_row;
        logic [5:0] last_row;
    } cfg_t;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic [7:0]        keep;
        logic [2:0]        page_number;
        logic [3:0]        byte_column;
    } page_load_t;

endpackage

// File: rtl/mbp_ram.sv
// ----------------------------------------------------------------------------
// mbp_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module mbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/mbp_merge.sv
// ----------------------------------------------------------------------------
// mbp_merge
// Line store read-modify-write: read the column word, merge the row byte,
// write back, and hand last-row words to the page serializer.
// ----------------------------------------------------------------------------
module mbp_merge (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  mbp_pkg::in_item_t   in_item,
    input  mbp_pkg::cfg_t       cfg,
    output logic                load_valid,
    input  logic                load_ready,
    output mbp_pkg::page_load_t load
);
    import mbp_pkg::*;

    logic                s1_valid_reg, s1_valid_next;
    in_item_t            s1_item_reg;
    logic                fwd_valid_reg;
    logic [COL_AW-1:0]   fwd_addr_reg;
    logic [WORD_W-1:0]   fwd_data_reg;

    logic                in_take;
    logic                in_keep;
    logic [5:0]          area_top;
    logic [5:0]          area_bottom;
    logic [WORD_W-1:0]   rdata;
    logic [WORD_W-1:0]   base_word;
    logic [WORD_W-1:0]   merged_word;
    logic [7:0]          keep_mask;
    logic [6:0]          pix_x;
    logic                needs_out;
    logic                s1_adv;
    logic [COL_AW-1:0]   s1_addr;

    assign area_top    = cfg.first_row & PAGE_MASK;
    assign area_bottom = (cfg.last_row & PAGE_MASK) + 6'd7;

    assign in_keep = (int'(in_item.row_index) < PANEL_HEIGHT)
                  && (int'(in_item.byte_column) < ROW_BYTES)
                  && (in_item.row_index >= area_top)
                  && (in_item.row_index <= area_bottom);

    assign in_take = in_valid && in_ready;
    assign s1_addr = s1_item_reg.byte_column[COL_AW-1:0];

    mbp_ram #(
        .WIDTH (WORD_W),
        .DEPTH (ROW_BYTES)
    ) u_line_store (
        .clk   (clk),
        .we    (s1_adv),
        .waddr (s1_addr),
        .wdata (merged_word),
        .re    (in_take),
        .raddr (in_item.byte_column[COL_AW-1:0]),
        .rdata (rdata)
    );

    assign base_word = (fwd_valid_reg && fwd_addr_reg == s1_addr) ? fwd_data_reg : rdata;

    always_comb
    begin
        for (int k = 0; k < PAGE_ROWS; k++)
        begin
            if (k == int'(s1_item_reg.row_index[2:0]))
            begin
                merged_word[8*k +: 8] = s1_item_reg.src_byte;
            end
            else
            begin
                merged_word[8*k +: 8] = base_word[8*k +: 8];
            end
        end
    end

    always_comb
    begin
        keep_mask = '0;
        pix_x     = '0;
        for (int b = 0; b < 8; b++)
        begin
            pix_x        = {s1_item_reg.byte_column, 3'(b)};
            keep_mask[b] = (pix_x >= cfg.first_column) && (pix_x <= cfg.last_column)
                        && (int'(pix_x) < PANEL_WIDTH);
        end
    end

    assign needs_out  = (s1_item_reg.row_index[2:0] == LAST_SUB) && (keep_mask != '0);
    assign load_valid = s1_valid_reg && needs_out;
    assign s1_adv     = s1_valid_reg && (!needs_out || load_ready);
    assign in_ready   = !s1_valid_reg || s1_adv;

    assign load.word        = merged_word;
    assign load.keep        = keep_mask;
    assign load.page_number = s1_item_reg.row_index[5:3];
    assign load.byte_column = s1_item_reg.byte_column;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_take && in_keep)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (s1_adv)
            begin
                fwd_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_item_reg <= in_item;
        end
        if (s1_adv)
        begin
            fwd_addr_reg <= s1_addr;
            fwd_data_reg <= merged_word;
        end
    end

endmodule

// File: rtl/mbp_serial.sv
// ----------------------------------------------------------------------------
// mbp_serial
// Page serializer: hold one column word and send one page byte per kept column.
// ----------------------------------------------------------------------------
module mbp_serial (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load_valid,
    output logic                load_ready,
    input  mbp_pkg::page_load_t load,
    output logic                out_valid,
    input  logic                out_ready,
    output mbp_pkg::out_item_t  out_item
);
    import mbp_pkg::*;

    logic [WORD_W-1:0] ex_word_reg;
    logic [7:0]        ex_mask_reg, ex_mask_next;
    logic [2:0]        ex_page_reg;
    logic [3:0]        ex_col_reg;

    logic [2:0]        sel;
    logic [7:0]        mask_rest;
    logic              out_take;
    logic              is_last;
    logic [7:0]        col_bits;

    always_comb
    begin
        sel = '0;
        for (int b = 7; b >= 0; b--)
        begin
            if (ex_mask_reg[b])
            begin
                sel = 3'(b);
            end
        end
    end

    assign mask_rest = ex_mask_reg & (ex_mask_reg - 8'd1);
    assign is_last   = (mask_rest == '0);
    assign out_valid = (ex_mask_reg != '0);
    assign out_take  = out_valid && out_ready;
    assign load_ready = !out_valid || (out_ready && is_last);

    always_comb
    begin
        for (int k = 0; k < PAGE_ROWS; k++)
        begin
            col_bits[k] = ex_word_reg[8*k + 7 - int'(sel)];
        end
    end

    assign out_item.page_byte    = col_bits;
    assign out_item.page_number  = ex_page_reg;
    assign out_item.pixel_column = {ex_col_reg, sel};
    assign out_item.run_last     = is_last;

    always_comb
    begin
        ex_mask_next = ex_mask_reg;
        if (load_valid && load_ready)
        begin
            ex_mask_next = load.keep;
        end
        else if (out_take)
        begin
            ex_mask_next = mask_rest;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ex_mask_reg <= '0;
        end
        else
        begin
            ex_mask_reg <= ex_mask_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_valid && load_ready)
        begin
            ex_word_reg <= load.word;
            ex_page_reg <= load.page_number;
            ex_col_reg  <= load.byte_column;
        end
    end

    a_load_mask: assert property (@(posedge clk) disable iff (!rst_n)
        load_valid && load_ready |=> ex_mask_reg == $past(load.keep))
        else $error("serializer did not take the loaded column mask");

    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !out_item.run_last |=> out_valid)
        else $error("page run ended before its last item");

    a_col_ascending: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !out_item.run_last
        |=> out_item.pixel_column > $past(out_item.pixel_column))
        else $error("page columns not ascending within a run");

    a_load_gap: assert property (@(posedge clk) disable iff (!rst_n)
        load_ready |-> !out_valid || (out_ready && out_item.run_last))
        else $error("serializer reloaded during a run");

endmodule

// File: rtl/mono_bitmap_to_page_bytes.sv
// ----------------------------------------------------------------------------
// mono_bitmap_to_page_bytes
// Row-major 1 bpp bytes in, vertical page bytes out through an 8-row store.
// ----------------------------------------------------------------------------
// Output: a last-row item is held in the merge stage register, then its page
//   word is loaded into the serializer, which offers the first page byte.
// Throughput: one item per cycle unless a last-row item must wait; the
//   serializer stays busy until it has sent each page byte (up to eight).
// Line store: one column word per byte column, read-modify-write, one access
//   each per cycle. Reset clears control and config, not the store.
module mono_bitmap_to_page_bytes (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  mbp_pkg::in_item_t  in_item,
    output logic               out_valid,
    input  logic               out_ready,
    output mbp_pkg::out_item_t out_item,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  mbp_pkg::cfg_reg_t  cfg_index,
    input  logic [6:0]         cfg_data
);
    import mbp_pkg::*;

    cfg_t       cfg_reg, cfg_next;
    logic       load_valid;
    logic       load_ready;
    page_load_t load;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_FIRST_COLUMN: cfg_next.first_column = cfg_data;
                REG_LAST_COLUMN:  cfg_next.last_column  = cfg_data;
                REG_FIRST_ROW:    cfg_next.first_row    = cfg_data[5:0];
                REG_LAST_ROW:     cfg_next.last_row     = cfg_data[5:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.first_column <= 7'd0;
            cfg_reg.last_column  <= 7'd127;
            cfg_reg.first_row    <= 6'd0;
            cfg_reg.last_row     <= 6'd63;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    mbp_merge u_merge (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_item    (in_item),
        .cfg        (cfg_reg),
        .load_valid (load_valid),
        .load_ready (load_ready),
        .load       (load)
    );

    mbp_serial u_serial (
        .clk        (clk),
        .rst_n      (rst_n),
        .load_valid (load_valid),
        .load_ready (load_ready),
        .load       (load),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_item   (out_item)
    );

endmodule
